>>> design/sha1bsh_pkg.sv
package sha1bsh_pkg;

    localparam logic [31:0] H_INIT0 = 32'h6745_2301;
    localparam logic [31:0] H_INIT1 = 32'hEFCD_AB89;
    localparam logic [31:0] H_INIT2 = 32'h98BA_DCFE;
    localparam logic [31:0] H_INIT3 = 32'h1032_5476;
    localparam logic [31:0] H_INIT4 = 32'hC3D2_E1F0;

    localparam logic [31:0] K_ROUND0 = 32'h5A82_7999;
    localparam logic [31:0] K_ROUND1 = 32'h6ED9_EBA1;
    localparam logic [31:0] K_ROUND2 = 32'h8F1B_BCDC;
    localparam logic [31:0] K_ROUND3 = 32'hCA62_C1D6;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam int BLOCK_WORDS = 16;
    localparam int LAST_ROUND  = 79;

    typedef logic [31:0] word_t;
    typedef logic [60:0] byte_count_t;

    function automatic word_t rotl1(input word_t x);
        return {x[30:0], x[31]};
    endfunction

    function automatic word_t rotl5(input word_t x);
        return {x[26:0], x[31:27]};
    endfunction

    function automatic word_t rotl30(input word_t x);
        return {x[1:0], x[31:2]};
    endfunction

endpackage

>>> design/sha1_byte_stream_hasher.sv
// SHA-1 hasher fed one byte per word on the s_ channel.
// Each input word carries s_data_byte when s_byte_valid is high; s_last closes
// the message after that word's byte (a closing word may carry no byte, which
// hashes the empty message). One digest word set leaves on the m_ channel per
// closed message, as m_digest_word0..4 (H0..H4).
//
// Bytes are accepted one per cycle while a block is being gathered. Each full
// 64-byte block then runs 80 rounds out of a 16-entry block memory with two
// registered read ports; each round has a read phase and an update phase
// because the schedule needs four memory reads per round. A block passes
// through a load step, the rounds and an add step, and no bytes are accepted
// meanwhile. After a closing word, padding is generated one byte per cycle to
// the end of the block (plus a further pad block and its compression when 56
// or more bytes are pending). s_ready is low from the closing word until the
// digest is loaded.
//
// The digest sits in an output register until taken. The next message can be
// gathered and compressed meanwhile, but its final step holds with s_ready low
// until m_ready frees the register. A synchronous reset (aresetn low) restores
// the initial chaining values and clears the byte count; memory needs no clearing.
module sha1_byte_stream_hasher
    import sha1bsh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_byte_valid,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word0,
    output logic [31:0] m_digest_word1,
    output logic [31:0] m_digest_word2,
    output logic [31:0] m_digest_word3,
    output logic [31:0] m_digest_word4
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LOAD,
        S_ROUND,
        S_ADD
    } state_t;

    state_t      state_reg;
    logic [5:0]  pos_reg;
    logic [23:0] word_reg;
    byte_count_t count_reg;
    logic        closing_reg;
    logic        final_blk_reg;
    logic        mark_done_reg;
    logic        len_mode_reg;
    logic [6:0]  round_reg;
    logic        phase_reg;
    word_t       x_reg;
    word_t       chain_reg [5];
    word_t       work_reg [5];
    word_t       dig_reg [5];
    logic        m_valid_reg;

    // Block memory: one write port, two registered read ports.
    word_t       block_mem [BLOCK_WORDS];
    word_t       rd0_reg;
    word_t       rd1_reg;
    logic [3:0]  rd_addr0;
    logic [3:0]  rd_addr1;
    logic        wr_en;
    logic [3:0]  wr_addr;
    word_t       wr_data;

    logic        accept;
    logic        put_en;
    logic [7:0]  put_byte;
    logic [7:0]  len_bytes [8];
    logic [63:0] bit_len;
    logic [3:0]  rl;
    word_t       w_val;
    word_t       f_val;
    word_t       k_val;
    word_t       t_val;
    logic        out_free;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign rl       = round_reg[3:0];
    assign bit_len  = {count_reg, 3'b000};

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            len_bytes[i] = bit_len[63 - 8 * i -: 8];
        end
    end

    // Byte source for the block gatherer: the input word or the padding sequence.
    always_comb begin
        put_en   = 1'b0;
        put_byte = s_data_byte;
        if (state_reg == S_IDLE) begin
            put_en   = accept && s_byte_valid;
            put_byte = s_data_byte;
        end else if (state_reg == S_PAD) begin
            put_en = 1'b1;
            if (!mark_done_reg) begin
                put_byte = PAD_MARK;
            end else if (!len_mode_reg && pos_reg != 6'd56) begin
                put_byte = 8'h00;
            end else begin
                put_byte = len_bytes[pos_reg[2:0]];
            end
        end
    end

    // Round datapath.
    always_comb begin
        if (round_reg >= 7'(BLOCK_WORDS)) begin
            w_val = rotl1(x_reg ^ rd0_reg ^ rd1_reg);
        end else begin
            w_val = rd1_reg;
        end
        if (round_reg < 7'd20) begin
            f_val = (work_reg[1] & work_reg[2]) | (~work_reg[1] & work_reg[3]);
            k_val = K_ROUND0;
        end else if (round_reg < 7'd40) begin
            f_val = work_reg[1] ^ work_reg[2] ^ work_reg[3];
            k_val = K_ROUND1;
        end else if (round_reg < 7'd60) begin
            f_val = (work_reg[1] & work_reg[2]) | (work_reg[1] & work_reg[3])
                  | (work_reg[2] & work_reg[3]);
            k_val = K_ROUND2;
        end else begin
            f_val = work_reg[1] ^ work_reg[2] ^ work_reg[3];
            k_val = K_ROUND3;
        end
        t_val = rotl5(work_reg[0]) + f_val + work_reg[4] + k_val + w_val;
    end

    // Read addresses: the first pair (t+13, t+8) is issued in the cycle before
    // the second pair (t+2, t). The round that writes entry t never reads back
    // an entry written by the round just before it, so no forwarding is needed.
    always_comb begin
        rd_addr0 = 4'(rl + 4'd14);
        rd_addr1 = 4'(rl + 4'd9);
        if (state_reg == S_LOAD) begin
            rd_addr0 = 4'd13;
            rd_addr1 = 4'd8;
        end else if (state_reg == S_ROUND && phase_reg) begin
            rd_addr0 = 4'(rl + 4'd2);
            rd_addr1 = rl;
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = pos_reg[5:2];
        wr_data = {word_reg, put_byte};
        if (put_en && pos_reg[1:0] == 2'b11) begin
            wr_en = 1'b1;
        end else if (state_reg == S_ROUND && !phase_reg
                     && round_reg >= 7'(BLOCK_WORDS)) begin
            wr_en   = 1'b1;
            wr_addr = rl;
            wr_data = w_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            block_mem[wr_addr] <= wr_data;
        end
        rd0_reg <= block_mem[rd_addr0];
        rd1_reg <= block_mem[rd_addr1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            count_reg     <= '0;
            closing_reg   <= 1'b0;
            final_blk_reg <= 1'b0;
            mark_done_reg <= 1'b0;
            len_mode_reg  <= 1'b0;
            round_reg     <= '0;
            phase_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
            chain_reg[0]  <= H_INIT0;
            chain_reg[1]  <= H_INIT1;
            chain_reg[2]  <= H_INIT2;
            chain_reg[3]  <= H_INIT3;
            chain_reg[4]  <= H_INIT4;
        end else begin
            // A digest loaded in the same cycle keeps the output valid.
            if (m_valid_reg && m_ready && !(state_reg == S_ADD && final_blk_reg)) begin
                m_valid_reg <= 1'b0;
            end

            if (put_en) begin
                pos_reg  <= 6'(pos_reg + 6'd1);
                word_reg <= {word_reg[15:0], put_byte};
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        if (s_byte_valid) begin
                            count_reg <= byte_count_t'(count_reg + 61'd1);
                        end
                        if (s_last) begin
                            closing_reg <= 1'b1;
                        end
                        if (s_byte_valid && pos_reg == 6'd63) begin
                            state_reg <= S_LOAD;
                        end else if (s_last) begin
                            state_reg <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    if (!mark_done_reg) begin
                        mark_done_reg <= 1'b1;
                    end else if (len_mode_reg || pos_reg == 6'd56) begin
                        len_mode_reg <= 1'b1;
                        if (pos_reg == 6'd63) begin
                            final_blk_reg <= 1'b1;
                        end
                    end
                    if (pos_reg == 6'd63) begin
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    for (int i = 0; i < 5; i++) begin
                        work_reg[i] <= chain_reg[i];
                    end
                    round_reg <= '0;
                    phase_reg <= 1'b1;
                    state_reg <= S_ROUND;
                end
                S_ROUND: begin
                    if (phase_reg) begin
                        x_reg     <= rd0_reg ^ rd1_reg;
                        phase_reg <= 1'b0;
                    end else begin
                        work_reg[4] <= work_reg[3];
                        work_reg[3] <= work_reg[2];
                        work_reg[2] <= rotl30(work_reg[1]);
                        work_reg[1] <= work_reg[0];
                        work_reg[0] <= t_val;
                        if (round_reg == 7'(LAST_ROUND)) begin
                            state_reg <= S_ADD;
                        end else begin
                            round_reg <= 7'(round_reg + 7'd1);
                            phase_reg <= 1'b1;
                        end
                    end
                end
                S_ADD: begin
                    if (!final_blk_reg) begin
                        for (int i = 0; i < 5; i++) begin
                            chain_reg[i] <= chain_reg[i] + work_reg[i];
                        end
                        round_reg <= '0;
                        state_reg <= closing_reg ? S_PAD : S_IDLE;
                    end else if (out_free) begin
                        // Hold here until the previous digest has been taken.
                        for (int i = 0; i < 5; i++) begin
                            dig_reg[i] <= chain_reg[i] + work_reg[i];
                        end
                        m_valid_reg   <= 1'b1;
                        chain_reg[0]  <= H_INIT0;
                        chain_reg[1]  <= H_INIT1;
                        chain_reg[2]  <= H_INIT2;
                        chain_reg[3]  <= H_INIT3;
                        chain_reg[4]  <= H_INIT4;
                        count_reg     <= '0;
                        closing_reg   <= 1'b0;
                        final_blk_reg <= 1'b0;
                        mark_done_reg <= 1'b0;
                        len_mode_reg  <= 1'b0;
                        round_reg     <= '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_digest_word0 = dig_reg[0];
    assign m_digest_word1 = dig_reg[1];
    assign m_digest_word2 = dig_reg[2];
    assign m_digest_word3 = dig_reg[3];
    assign m_digest_word4 = dig_reg[4];

    a_close_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last) |=> !s_ready)
        else $error("input still ready after a closing word");

    a_round_range: assert property (@(posedge aclk) disable iff (!aresetn)
        round_reg <= 7'(LAST_ROUND))
        else $error("round index out of range");

    a_load_on_full_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LOAD) |-> (pos_reg == 6'd0))
        else $error("compression started on a partial block");

    a_digest_from_add: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == S_ADD && $past(final_blk_reg)))
        else $error("digest loaded outside the final block");

    a_final_has_len: assert property (@(posedge aclk) disable iff (!aresetn)
        final_blk_reg |-> (closing_reg && len_mode_reg && mark_done_reg))
        else $error("final block flagged without a length field");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import sha1bsh_pkg::*;

    typedef logic [159:0] digest_t;

    typedef struct packed {
        logic [7:0] data;
        logic       carries;
        logic       closes;
        logic       typed;
        digest_t    digest;
    } probe_row_t;

    localparam int CYCLE_LIMIT = 600_000;
    localparam int ITEM_TARGET = 1450;
    localparam int MIN_MESSAGES = 26;
    localparam int HOLD_CYCLES = 3000;

    localparam digest_t EMPTY_DIGEST = 160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
    localparam digest_t ABC_DIGEST   = 160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;
    localparam digest_t NO_DIGEST    = '0;

    localparam int BOUNDARY_LENGTHS [18] = '{0, 1, 3, 4, 54, 55, 56, 57, 62, 63, 64, 65,
                                             118, 119, 120, 121, 127, 128};

    // Directed words: each row is one word offered on the input channel.
    localparam probe_row_t PROBE_ROWS [16] = '{
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_DIGEST},
        '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
        '{8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        '{8'h62, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
        '{8'hA5, 1'b0, 1'b0, 1'b0, NO_DIGEST},
        '{8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        '{8'h62, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        '{8'hFF, 1'b0, 1'b0, 1'b0, NO_DIGEST},
        '{8'h63, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        '{8'h5A, 1'b0, 1'b1, 1'b1, ABC_DIGEST},
        '{8'hFF, 1'b1, 1'b1, 1'b0, NO_DIGEST},
        '{8'h00, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        '{8'hFF, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        '{8'h00, 1'b1, 1'b1, 1'b0, NO_DIGEST},
        '{8'h80, 1'b1, 1'b1, 1'b0, NO_DIGEST}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_byte_valid = 1'b0;
    logic        s_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_digest_word0;
    logic [31:0] m_digest_word1;
    logic [31:0] m_digest_word2;
    logic [31:0] m_digest_word3;
    logic [31:0] m_digest_word4;

    sha1_byte_stream_hasher dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_byte_valid   (s_byte_valid),
        .s_last         (s_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_digest_word0 (m_digest_word0),
        .m_digest_word1 (m_digest_word1),
        .m_digest_word2 (m_digest_word2),
        .m_digest_word3 (m_digest_word3),
        .m_digest_word4 (m_digest_word4)
    );

    always #10 aclk = ~aclk;

    digest_t     digests_due [$];
    int          mismatches = 0;
    int          digests_seen = 0;
    int          hold_left = 0;
    int          items_sent = 0;
    int          cycles = 0;
    bit          steady = 1'b0;

    // Predictor state: message schedule ring, chaining words, length and block fill.
    word_t       sched [BLOCK_WORDS];
    word_t       chain [5];
    byte_count_t msg_len;
    logic [5:0]  fill;

    function automatic void chain_reset();
        chain[0] = H_INIT0;
        chain[1] = H_INIT1;
        chain[2] = H_INIT2;
        chain[3] = H_INIT3;
        chain[4] = H_INIT4;
        msg_len = '0;
        fill = '0;
    endfunction

    function automatic void compress_block();
        word_t v [5];
        word_t w, f, k, t;
        int    i, r;
        for (i = 0; i < 5; i++) v[i] = chain[i];
        for (r = 0; r < 80; r++) begin
            if (r >= 16) begin
                w = sched[(r + 13) % 16] ^ sched[(r + 8) % 16] ^ sched[(r + 2) % 16]
                    ^ sched[r % 16];
                w = {w[30:0], w[31]};
                sched[r % 16] = w;
            end else begin
                w = sched[r];
            end
            if (r < 20) begin
                f = (v[1] & v[2]) | (~v[1] & v[3]);
                k = K_ROUND0;
            end else if (r < 40) begin
                f = v[1] ^ v[2] ^ v[3];
                k = K_ROUND1;
            end else if (r < 60) begin
                f = (v[1] & v[2]) | (v[1] & v[3]) | (v[2] & v[3]);
                k = K_ROUND2;
            end else begin
                f = v[1] ^ v[2] ^ v[3];
                k = K_ROUND3;
            end
            t = {v[0][26:0], v[0][31:27]} + f + v[4] + k + w;
            v[4] = v[3];
            v[3] = v[2];
            v[2] = {v[1][1:0], v[1][31:2]};
            v[1] = v[0];
            v[0] = t;
        end
        for (i = 0; i < 5; i++) chain[i] = chain[i] + v[i];
    endfunction

    function automatic void absorb_byte(input logic [7:0] b);
        logic [3:0] slot;
        logic [1:0] lane;
        slot = fill[5:2];
        lane = fill[1:0];
        if (lane == 2'd0) sched[slot] = '0;
        sched[slot][31 - 8 * lane -: 8] = b;
        fill = fill + 6'd1;
        if (fill == 6'd0) compress_block();
    endfunction

    // Returns 1 when the word closes a message, with the digest it should produce.
    function automatic logic hash_word(input logic [7:0] d, input logic carries,
                                       input logic closes, output digest_t digest);
        logic [63:0] bit_len;
        int          i;
        digest = '0;
        if (carries) begin
            msg_len = msg_len + 1'b1;
            absorb_byte(d);
        end
        if (!closes) return 1'b0;
        bit_len = {msg_len, 3'b000};
        absorb_byte(PAD_MARK);
        while (fill != 6'd56) absorb_byte(8'h00);
        for (i = 0; i < 8; i++) absorb_byte(bit_len[63 - 8 * i -: 8]);
        digest = {chain[0], chain[1], chain[2], chain[3], chain[4]};
        chain_reset();
        return 1'b1;
    endfunction

    task automatic offer_word(input logic [7:0] d, input logic carries, input logic closes,
                              input logic typed, input digest_t typed_digest);
        digest_t digest;
        logic    has_digest;
        if (!steady && $urandom_range(99) < 28) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(2, 1)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_data_byte  <= d;
        s_byte_valid <= carries;
        s_last       <= closes;
        do @(posedge aclk); while (s_ready !== 1'b1);
        items_sent++;
        has_digest = hash_word(d, carries, closes, digest);
        if (has_digest) digests_due.push_back(typed ? typed_digest : digest);
    endtask

    function automatic int pick_length();
        int sel;
        sel = $urandom_range(99);
        if (sel < 20) return BOUNDARY_LENGTHS[$urandom_range(17)];
        if (sel < 85) return $urandom_range(40);
        if (sel < 98) return $urandom_range(140, 41);
        return $urandom_range(260, 141);
    endfunction

    // A message may close on its last byte or on a separate word with no byte,
    // and idle words are scattered between the bytes.
    task automatic send_message(input int len);
        int   i;
        logic split_close;
        split_close = (len == 0) || ($urandom_range(1) == 1);
        for (i = 0; i < len; i++) begin
            if ($urandom_range(99) < 8)
                offer_word(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, NO_DIGEST);
            offer_word(8'($urandom_range(255)), 1'b1, !split_close && (i == len - 1),
                       1'b0, NO_DIGEST);
        end
        if (split_close) offer_word(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, NO_DIGEST);
    endtask

    always @(posedge aclk) begin
        digest_t     got, want;
        logic [31:0] got_w, want_w;
        int          i;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            got = {m_digest_word0, m_digest_word1, m_digest_word2, m_digest_word3,
                   m_digest_word4};
            if (digests_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected digest %h", got);
            end else begin
                want = digests_due.pop_front();
                for (i = 0; i < 5; i++) begin
                    got_w  = got[159 - 32 * i -: 32];
                    want_w = want[159 - 32 * i -: 32];
                    if (got_w !== want_w) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("digest %0d, digest_word%0d: expected %h, got %h",
                                     digests_seen, i, want_w, got_w);
                    end
                end
            end
            digests_seen++;
            // Starve the output long enough that the next close backs up the input.
            if (digests_seen == 12) hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn && (steady || $urandom_range(99) >= 28);
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("** sha1_byte_stream_hasher: FAILED **");
            $finish;
        end
    end

    initial begin
        int row;
        int msgs;
        chain_reset();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (row = 0; row < 16; row++)
            offer_word(PROBE_ROWS[row].data, PROBE_ROWS[row].carries, PROBE_ROWS[row].closes,
                       PROBE_ROWS[row].typed, PROBE_ROWS[row].digest);
        msgs = 0;
        while (items_sent < ITEM_TARGET || msgs < MIN_MESSAGES) begin
            steady = (msgs >= 16 && msgs < 26);
            if (msgs == 12) begin
                s_valid <= 1'b0;
                while (digests_due.size() != 0) @(posedge aclk);
            end
            send_message(pick_length());
            msgs++;
        end
        steady = 1'b0;
        s_valid <= 1'b0;
        while (digests_due.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (mismatches == 0 && digests_due.size() == 0)
            $display("** sha1_byte_stream_hasher: PASSED **");
        else
            $display("** sha1_byte_stream_hasher: FAILED **");
        $finish;
    end

endmodule

>>> sha1_byte_stream_hasher.f
design/sha1bsh_pkg.sv
design/sha1_byte_stream_hasher.sv
verif/testbench.sv
